/* rtl/tke_pkg.sv */
// ----------------------------------------------------------------------------
// Trajectory kinematics estimator package
// Shared constants and register codes for the kinematics estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package tke_pkg;

   // Configuration register index.
   typedef logic [0:0] csr_index_type;

   localparam csr_index_type CSR_INV_FRAME_TIME   = 1'b0;
   localparam csr_index_type CSR_HISTORY_DISCOUNT = 1'b1;

   // Register reset values.
   localparam logic [15:0] INV_FRAME_TIME_RESET   = 16'd640;
   localparam logic [15:0] HISTORY_DISCOUNT_RESET = 16'd52429;

   // Saturation limits of the result fields.
   localparam logic [23:0] VEL_MAX     = 24'h7FFFFF;
   localparam logic [23:0] VEL_MIN     = 24'h800000;
   localparam logic [22:0] SPEED_MAX   = 23'h7FFFFF;
   localparam logic [15:0] HEADING_MAX = 16'h7FFF;

   // Sample counter saturates here.
   localparam logic [2:0] SAMPLES_MAX = 3'd7;

   // Norm inputs are brought below this bound before squaring.
   localparam logic [63:0] NORM_LIMIT = 64'd16777216;

   // Weight of the current speed in the weighted average (1.0 in Q3.16).
   localparam logic [18:0] WEIGHT_ONE = 19'd65536;

endpackage

`default_nettype wire

/* rtl/trajectory_kinematics_estimator.sv */
// ----------------------------------------------------------------------------
// Trajectory kinematics estimator
// Finite-difference velocity, speed, heading, acceleration and discounted
// average speed from one tracked 2-D position per frame.
// ----------------------------------------------------------------------------
`default_nettype none

// Each item is worked on alone: req_ready is high only while the sequencer is
// idle, and a finished result sits in an output register so the next item can
// be taken while it waits. The time from one accepted item to the next is set
// by the shared subtract and compare unit, which runs the 32-step square root,
// two 16-step heading divisions and the 23-step division of the weighted
// average, plus the shifts of the norm scaling (up to POS_WIDTH - 24) and the
// S_WH, S_WW and S_WN states of each history tap in use. A first sample of a
// track skips this work and goes straight to the hand-over. A stalled result
// channel holds the sequencer in its hand-over state while the result register
// stays full. The one multiplier handles all products, one per cycle.
module trajectory_kinematics_estimator #(
   parameter int HISTORY_TAPS = 3,
   parameter int POS_WIDTH    = 24
) (
   input  wire                        clock,
   input  wire                        reset,
   // Configuration port
   input  wire                        csr_we,
   input  tke_pkg::csr_index_type     csr_index,
   input  wire  [15:0]                csr_wdata,
   // Input channel
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  signed [POS_WIDTH-1:0] req_pos_x,
   input  wire  signed [POS_WIDTH-1:0] req_pos_y,
   input  wire                        req_track_start,
   // Result channel
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic signed [23:0]         rsp_vel_x,
   output logic signed [23:0]         rsp_vel_y,
   output logic [22:0]                rsp_speed,
   output logic signed [15:0]         rsp_heading_x,
   output logic signed [15:0]         rsp_heading_y,
   output logic [22:0]                rsp_weighted_speed,
   output logic signed [23:0]         rsp_acc_x,
   output logic signed [23:0]         rsp_acc_y,
   output logic                       rsp_vel_valid,
   output logic                       rsp_acc_valid
);
   import tke_pkg::*;

   localparam int W    = POS_WIDTH;
   localparam int KMAX = (W > 24) ? (W - 24) : 0;
   localparam int KW   = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
   localparam int AW   = 32 + KMAX;
   localparam int PW   = AW + 24;
   localparam int TW   = $clog2(HISTORY_TAPS + 1);
   localparam int IW   = (HISTORY_TAPS > 1) ? $clog2(HISTORY_TAPS) : 1;

   typedef enum logic [4:0] {
      S_IDLE, S_NORM, S_MVX, S_MVY, S_MAX, S_MAY, S_MSQX, S_MSQY,
      S_SQLD, S_SQRT, S_MSPD, S_HXLD, S_HX, S_HYLD, S_HY, S_WLD,
      S_WH, S_WW, S_WN, S_WDLD, S_WDIV, S_FIN
   } state_type;

   // Velocity scaling: drop 8 fraction bits and saturate by sign.
   function automatic logic [23:0] sat_vel(input logic [PW-1:0] prod, input logic neg);
      logic [PW-1:0] p;
      logic [23:0]   r;
      p = prod >> 8;
      if (neg) begin
         r = (64'(p) > 64'(VEL_MIN)) ? VEL_MIN : 24'(-p[23:0]);
      end else begin
         r = (64'(p) > 64'(VEL_MAX)) ? VEL_MAX : p[23:0];
      end
      return r;
   endfunction

   // Heading component from the division quotient.
   function automatic logic [15:0] head_val(input logic [15:0] q, input logic neg,
                                            input logic zero_root);
      logic [15:0] h;
      h = (q > HEADING_MAX) ? HEADING_MAX : q;
      if (zero_root) begin
         h = '0;
      end else if (neg) begin
         h = 16'(-h);
      end
      return h;
   endfunction

   state_type state_ff;

   // Configuration and track state.
   logic [15:0]          inv_ff, disc_ff;
   logic signed [W-1:0]  last_x_ff, last_y_ff;
   logic [23:0]          last_vx_ff, last_vy_ff;
   logic [22:0]          hist_ff [HISTORY_TAPS];
   logic [2:0]           samples_ff;

   // Item datapath.
   logic signed [W-1:0]  x_ff, y_ff;
   logic                 first_ff, negx_ff, negy_ff;
   logic [W-1:0]         magx_ff, magy_ff, shx_ff, shy_ff;
   logic [KW-1:0]        k_ff;
   logic [23:0]          vx_ff, vy_ff, accx_ff, accy_ff;
   logic [47:0]          sq_ff;
   logic [PW-1:0]        prod_ff;
   logic [63:0]          rem_ff, root_ff, dvs_ff;
   logic [22:0]          quo_ff;
   logic [4:0]           cnt_ff;
   logic [22:0]          spd_ff;
   logic [15:0]          hx_ff, hy_ff, w_ff;
   logic [41:0]          num_ff;
   logic [18:0]          den_ff;
   logic [TW-1:0]        tap_ff;

   // Result register.
   logic                 out_valid_ff;
   logic [23:0]          out_vx_ff, out_vy_ff, out_ax_ff, out_ay_ff;
   logic [22:0]          out_spd_ff, out_wspd_ff;
   logic [15:0]          out_hx_ff, out_hy_ff;
   logic                 out_vv_ff, out_av_ff;

   // Position steps of an arriving item.
   logic signed [W:0]    dx_c, dy_c;
   assign dx_c = {req_pos_x[W-1], req_pos_x} - {last_x_ff[W-1], last_x_ff};
   assign dy_c = {req_pos_y[W-1], req_pos_y} - {last_y_ff[W-1], last_y_ff};

   // Velocity differences for the acceleration.
   logic [24:0]          dvx_c, dvy_c;
   logic [23:0]          dvx_mag, dvy_mag;
   assign dvx_c   = {vx_ff[23], vx_ff} - {last_vx_ff[23], last_vx_ff};
   assign dvy_c   = {vy_ff[23], vy_ff} - {last_vy_ff[23], last_vy_ff};
   assign dvx_mag = dvx_c[24] ? 24'(-dvx_c) : dvx_c[23:0];
   assign dvy_mag = dvy_c[24] ? 24'(-dvy_c) : dvy_c[23:0];

   // Number of history taps in use for this item.
   logic [2:0]           sm1_c;
   logic [TW-1:0]        nh_c;
   assign sm1_c = samples_ff - 3'd1;
   assign nh_c  = (32'(sm1_c) > HISTORY_TAPS) ? TW'(HISTORY_TAPS) : TW'(sm1_c);

   // Shared multiplier operand selection.
   logic [AW-1:0]        mul_a;
   logic [23:0]          mul_b;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MVX:   begin mul_a = AW'(magx_ff); mul_b = 24'(inv_ff); end
         S_MVY:   begin mul_a = AW'(magy_ff); mul_b = 24'(inv_ff); end
         S_MAX:   begin mul_a = AW'(dvx_mag); mul_b = 24'(inv_ff); end
         S_MAY:   begin mul_a = AW'(dvy_mag); mul_b = 24'(inv_ff); end
         S_MSQX:  begin mul_a = AW'(24'(shx_ff)); mul_b = 24'(shx_ff); end
         S_MSQY:  begin mul_a = AW'(24'(shy_ff)); mul_b = 24'(shy_ff); end
         S_MSPD:  begin mul_a = AW'(root_ff[31:0]) << k_ff; mul_b = 24'(inv_ff); end
         S_WH:    begin mul_a = AW'(hist_ff[tap_ff[IW-1:0]]); mul_b = 24'(w_ff); end
         S_WW:    begin mul_a = AW'(w_ff); mul_b = 24'(w_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // Shared subtract and compare unit: square root trial or shifted divisor.
   logic [63:0]          trial_c;
   logic [64:0]          diff_c;
   logic                 ge_c;
   assign trial_c = (state_ff == S_SQRT) ? (root_ff + dvs_ff) : dvs_ff;
   assign diff_c  = {1'b0, rem_ff} - {1'b0, trial_c};
   assign ge_c    = !diff_c[64];

   logic [PW-1:0]        spd_p;
   assign spd_p = prod_ff >> 15;

   logic                 out_free;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // Multiplier output register.
   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
   end

   // Sequencer, datapath, track state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         inv_ff       <= INV_FRAME_TIME_RESET;
         disc_ff      <= HISTORY_DISCOUNT_RESET;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         last_vx_ff   <= '0;
         last_vy_ff   <= '0;
         samples_ff   <= '0;
         for (int j = 0; j < HISTORY_TAPS; j++) begin
            hist_ff[j] <= '0;
         end
      end else begin
         // Configuration writes.
         if (csr_we) begin
            unique case (csr_index)
               CSR_INV_FRAME_TIME:   inv_ff  <= csr_wdata;
               CSR_HISTORY_DISCOUNT: disc_ff <= csr_wdata;
            endcase
         end

         // A taken result empties the register unless a new one enters.
         if (out_valid_ff && rsp_ready && (state_ff != S_FIN)) begin
            out_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x_ff     <= req_pos_x;
                  y_ff     <= req_pos_y;
                  first_ff <= req_track_start || (samples_ff == 3'd0);
                  negx_ff  <= dx_c[W];
                  negy_ff  <= dy_c[W];
                  magx_ff  <= dx_c[W] ? W'(-dx_c) : W'(dx_c);
                  magy_ff  <= dy_c[W] ? W'(-dy_c) : W'(dy_c);
                  shx_ff   <= dx_c[W] ? W'(-dx_c) : W'(dx_c);
                  shy_ff   <= dy_c[W] ? W'(-dy_c) : W'(dy_c);
                  k_ff     <= '0;
                  state_ff <= (req_track_start || (samples_ff == 3'd0)) ? S_FIN : S_NORM;
               end
            end
            // Scale both magnitudes down together until they fit 24 bits.
            S_NORM: begin
               if ((64'(shx_ff) >= NORM_LIMIT) || (64'(shy_ff) >= NORM_LIMIT)) begin
                  shx_ff <= shx_ff >> 1;
                  shy_ff <= shy_ff >> 1;
                  k_ff   <= k_ff + KW'(1);
               end else begin
                  state_ff <= S_MVX;
               end
            end
            S_MVX: state_ff <= S_MVY;
            S_MVY: begin
               vx_ff    <= sat_vel(prod_ff, negx_ff);
               state_ff <= S_MAX;
            end
            S_MAX: begin
               vy_ff    <= sat_vel(prod_ff, negy_ff);
               state_ff <= S_MAY;
            end
            S_MAY: begin
               accx_ff  <= sat_vel(prod_ff, dvx_c[24]);
               state_ff <= S_MSQX;
            end
            S_MSQX: begin
               accy_ff  <= sat_vel(prod_ff, dvy_c[24]);
               state_ff <= S_MSQY;
            end
            S_MSQY: begin
               sq_ff    <= prod_ff[47:0];
               state_ff <= S_SQLD;
            end
            S_SQLD: begin
               rem_ff   <= (64'(sq_ff) + 64'(prod_ff[47:0])) << 14;
               root_ff  <= '0;
               dvs_ff   <= 64'd1 << 62;
               cnt_ff   <= 5'd31;
               state_ff <= S_SQRT;
            end
            // One result bit of the square root per cycle.
            S_SQRT: begin
               if (ge_c) begin
                  rem_ff  <= diff_c[63:0];
                  root_ff <= (root_ff >> 1) + dvs_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               dvs_ff <= dvs_ff >> 2;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  state_ff <= S_MSPD;
               end
            end
            S_MSPD: state_ff <= S_HXLD;
            S_HXLD: begin
               spd_ff   <= (64'(spd_p) > 64'(SPEED_MAX)) ? SPEED_MAX : spd_p[22:0];
               rem_ff   <= 64'(24'(shx_ff)) << 22;
               dvs_ff   <= 64'(root_ff[31:0]) << 15;
               quo_ff   <= '0;
               cnt_ff   <= 5'd15;
               state_ff <= S_HX;
            end
            S_HX, S_HY, S_WDIV: begin
               // Restoring division, one quotient bit per cycle.
               if (ge_c) begin
                  rem_ff <= diff_c[63:0];
               end
               quo_ff <= {quo_ff[21:0], ge_c};
               dvs_ff <= dvs_ff >> 1;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  priority case (state_ff)
                     S_HX:    state_ff <= S_HYLD;
                     S_HY:    state_ff <= S_WLD;
                     default: state_ff <= S_FIN;
                  endcase
               end
            end
            S_HYLD: begin
               hx_ff    <= head_val(quo_ff[15:0], negx_ff, root_ff[31:0] == 32'd0);
               rem_ff   <= 64'(24'(shy_ff)) << 22;
               dvs_ff   <= 64'(root_ff[31:0]) << 15;
               quo_ff   <= '0;
               cnt_ff   <= 5'd15;
               state_ff <= S_HY;
            end
            S_WLD: begin
               hy_ff    <= head_val(quo_ff[15:0], negy_ff, root_ff[31:0] == 32'd0);
               num_ff   <= 42'(spd_ff) << 16;
               den_ff   <= WEIGHT_ONE;
               w_ff     <= disc_ff;
               tap_ff   <= '0;
               state_ff <= (nh_c == '0) ? S_WDLD : S_WH;
            end
            // Per tap: history times weight, then the next weight as a square.
            S_WH: begin
               den_ff   <= den_ff + 19'(w_ff);
               state_ff <= S_WW;
            end
            S_WW: begin
               num_ff   <= num_ff + 42'(prod_ff[38:0]);
               state_ff <= S_WN;
            end
            S_WN: begin
               w_ff     <= prod_ff[31:16];
               tap_ff   <= tap_ff + TW'(1);
               state_ff <= ((tap_ff + TW'(1)) == nh_c) ? S_WDLD : S_WH;
            end
            S_WDLD: begin
               rem_ff   <= 64'(num_ff);
               dvs_ff   <= 64'(den_ff) << 22;
               quo_ff   <= '0;
               cnt_ff   <= 5'd22;
               state_ff <= S_WDIV;
            end
            // Hand the item over and update the track state.
            S_FIN: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  last_x_ff    <= x_ff;
                  last_y_ff    <= y_ff;
                  if (first_ff) begin
                     out_vx_ff   <= '0;
                     out_vy_ff   <= '0;
                     out_spd_ff  <= '0;
                     out_hx_ff   <= '0;
                     out_hy_ff   <= '0;
                     out_wspd_ff <= '0;
                     out_ax_ff   <= '0;
                     out_ay_ff   <= '0;
                     out_vv_ff   <= 1'b0;
                     out_av_ff   <= 1'b0;
                     last_vx_ff  <= '0;
                     last_vy_ff  <= '0;
                     samples_ff  <= 3'd1;
                     for (int j = 0; j < HISTORY_TAPS; j++) begin
                        hist_ff[j] <= '0;
                     end
                  end else begin
                     out_vx_ff   <= vx_ff;
                     out_vy_ff   <= vy_ff;
                     out_spd_ff  <= spd_ff;
                     out_hx_ff   <= hx_ff;
                     out_hy_ff   <= hy_ff;
                     out_wspd_ff <= quo_ff;
                     out_vv_ff   <= 1'b1;
                     if (samples_ff >= 3'd2) begin
                        out_ax_ff <= accx_ff;
                        out_ay_ff <= accy_ff;
                        out_av_ff <= 1'b1;
                     end else begin
                        out_ax_ff <= '0;
                        out_ay_ff <= '0;
                        out_av_ff <= 1'b0;
                     end
                     last_vx_ff <= vx_ff;
                     last_vy_ff <= vy_ff;
                     if (samples_ff < SAMPLES_MAX) begin
                        samples_ff <= samples_ff + 3'd1;
                     end
                     for (int j = HISTORY_TAPS - 1; j > 0; j--) begin
                        hist_ff[j] <= hist_ff[j-1];
                     end
                     hist_ff[0] <= spd_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Result ports.
   assign rsp_valid          = out_valid_ff;
   assign rsp_vel_x          = out_vx_ff;
   assign rsp_vel_y          = out_vy_ff;
   assign rsp_speed          = out_spd_ff;
   assign rsp_heading_x      = out_hx_ff;
   assign rsp_heading_y      = out_hy_ff;
   assign rsp_weighted_speed = out_wspd_ff;
   assign rsp_acc_x          = out_ax_ff;
   assign rsp_acc_y          = out_ay_ff;
   assign rsp_vel_valid      = out_vv_ff;
   assign rsp_acc_valid      = out_av_ff;

endmodule

`default_nettype wire
